@@ hdl/assert_macros.svh @@
// Assertion macros shared by the distance core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define QLAD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// When trig holds, cons must hold at the next clock edge.
`define QLAD_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qlad_pkg.sv @@
// Types, constants and register codes of the quantized L2 distance core.
package qlad_pkg;

  localparam int unsigned MaxDim       = 4096;
  localparam int unsigned CodebookSize = 16;
  localparam int unsigned ValueBits    = 16;
  localparam int unsigned DimW         = 13;
  localparam int unsigned SumW         = 48;
  localparam int unsigned MagW         = ValueBits;
  localparam int unsigned SqW          = 2 * MagW;
  localparam int unsigned FifoDepth    = 2;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned CbWords      = 4;

  // Index extraction masks
  localparam logic [7:0] Mask4 = 8'h0F;
  localparam logic [7:0] Mask2 = 8'h03;
  localparam logic [7:0] Mask3 = 8'h07;
  localparam logic [7:0] Mask1 = 8'h01;

  // Supported code widths
  localparam logic [2:0] CodeBits1 = 3'd1;
  localparam logic [2:0] CodeBits2 = 3'd2;
  localparam logic [2:0] CodeBits3 = 3'd3;
  localparam logic [2:0] CodeBits4 = 3'd4;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CfgMode     = 3'd0,
    CfgCodeBits = 3'd1,
    CfgDimCount = 3'd2,
    CfgCbWord0  = 3'd3,
    CfgCbWord1  = 3'd4,
    CfgCbWord2  = 3'd5,
    CfgCbWord3  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ValueBits-1:0] query_value;
    logic signed [ValueBits-1:0] peer_value;
    logic [7:0]                  code_byte;
    logic [7:0]                  code_next_byte;
  } in_item_t;

  typedef struct packed {
    logic [SumW-1:0] distance;
  } out_item_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] wdata;
  } cfg_req_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            last;
  } work_t;

endpackage

@@ hdl/qlad_stream_if.sv @@
// Valid/ready channel carrying one request of a given payload type.
interface qlad_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/qlad_fifo.sv @@
// Short work queue between the front and back parts.
`include "assert_macros.svh"

module qlad_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  qlad_pkg::work_t    wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output qlad_pkg::work_t    rd_data_o
);

  localparam int unsigned PtrW = (qlad_pkg::FifoDepth > 1) ? $clog2(qlad_pkg::FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(qlad_pkg::FifoDepth + 1);

  qlad_pkg::work_t mem_q [qlad_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != CntW'(qlad_pkg::FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(qlad_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(qlad_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `QLAD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(qlad_pkg::FifoDepth), "fifo overfilled")
  `QLAD_ASSERT(a_ptr_gap, clk_i, rst_ni,
               (cnt_q == '0 || cnt_q == CntW'(qlad_pkg::FifoDepth)) == (wr_ptr_q == rd_ptr_q),
               "fifo pointers disagree with count")

endmodule

@@ hdl/qlad_front.sv @@
// Front part: config registers, dimension counter, index extraction, difference.
`include "assert_macros.svh"

module qlad_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  qlad_stream_if.sink     in_i,
  qlad_stream_if.sink     cfg_i,
  output logic            work_valid_o,
  input  logic            work_ready_i,
  output qlad_pkg::work_t work_o
);

  logic                           mode_q;
  logic [2:0]                     code_bits_q;
  logic [qlad_pkg::DimW-1:0]      dim_count_q;
  logic [qlad_pkg::CfgDataW-1:0]  cb_q [qlad_pkg::CbWords];
  logic [qlad_pkg::DimW-1:0]      dim_idx_q, dim_idx_d;

  logic                           accept;
  logic [7:0]                     b0, b1;
  logic [2:0]                     sh3;
  logic [3:0]                     idx;
  logic                           supported;
  logic [qlad_pkg::CfgDataW-1:0]  cb_word;
  logic signed [qlad_pkg::ValueBits-1:0] cent, other;
  logic signed [qlad_pkg::ValueBits:0]   diff;
  logic [qlad_pkg::MagW-1:0]      mag;
  logic [qlad_pkg::DimW-1:0]      limit;
  logic                           last;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = work_ready_i;
  assign accept      = in_i.valid && work_ready_i;
  assign b0          = in_i.data.code_byte;
  assign b1          = in_i.data.code_next_byte;
  // 3i mod 8 without a multiplier
  assign sh3         = dim_idx_q[2:0] + {dim_idx_q[1:0], 1'b0};

  // Codebook index from the packed bytes
  always_comb begin
    idx       = '0;
    supported = 1'b1;
    unique case (code_bits_q)
      qlad_pkg::CodeBits4: idx = dim_idx_q[0] ? 4'(b0 & qlad_pkg::Mask4) : 4'(b0 >> 4);
      qlad_pkg::CodeBits2: idx = 4'((b0 >> (3'd6 - {dim_idx_q[1:0], 1'b0})) & qlad_pkg::Mask2);
      qlad_pkg::CodeBits1: idx = 4'((b0 >> (3'd7 - dim_idx_q[2:0])) & qlad_pkg::Mask1);
      qlad_pkg::CodeBits3: idx = 4'(({b1, b0} >> sh3) & {8'h00, qlad_pkg::Mask3});
      default:             supported = 1'b0;
    endcase
  end

  // Centroid lookup and difference magnitude
  always_comb begin
    cb_word = cb_q[idx[3:2]];
    cent    = cb_word[{idx[1:0], 4'b0000} +: qlad_pkg::ValueBits];
    if (32'(idx) >= qlad_pkg::CodebookSize) begin
      cent = '0;
    end
    other = mode_q ? cent : in_i.data.peer_value;
    diff  = {in_i.data.query_value[qlad_pkg::ValueBits-1], in_i.data.query_value}
          - {other[qlad_pkg::ValueBits-1], other};
    mag   = diff[qlad_pkg::ValueBits] ? qlad_pkg::MagW'(-diff) : diff[qlad_pkg::MagW-1:0];
    if (mode_q && !supported) begin
      mag = '0;
    end
  end

  // Effective vector length, clamped to 1..MaxDim
  always_comb begin
    limit = dim_count_q;
    if (dim_count_q == '0) begin
      limit = qlad_pkg::DimW'(1);
    end else if (32'(dim_count_q) > qlad_pkg::MaxDim) begin
      limit = qlad_pkg::DimW'(qlad_pkg::MaxDim);
    end
    last = ({1'b0, dim_idx_q} + 1'b1) >= {1'b0, limit};
  end

  assign dim_idx_d    = last ? '0 : dim_idx_q + 1'b1;
  assign work_valid_o = in_i.valid;
  assign work_o.mag   = mag;
  assign work_o.last  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_idx_q <= '0;
    end else if (accept) begin
      dim_idx_q <= dim_idx_d;
    end
  end

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      code_bits_q <= qlad_pkg::CodeBits4;
      dim_count_q <= qlad_pkg::DimW'(1);
      for (int w = 0; w < qlad_pkg::CbWords; w++) begin
        cb_q[w] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (qlad_pkg::cfg_reg_e'(cfg_i.data.addr))
        qlad_pkg::CfgMode:     mode_q      <= cfg_i.data.wdata[0];
        qlad_pkg::CfgCodeBits: code_bits_q <= cfg_i.data.wdata[2:0];
        qlad_pkg::CfgDimCount: dim_count_q <= cfg_i.data.wdata[qlad_pkg::DimW-1:0];
        qlad_pkg::CfgCbWord0:  cb_q[0]     <= cfg_i.data.wdata;
        qlad_pkg::CfgCbWord1:  cb_q[1]     <= cfg_i.data.wdata;
        qlad_pkg::CfgCbWord2:  cb_q[2]     <= cfg_i.data.wdata;
        qlad_pkg::CfgCbWord3:  cb_q[3]     <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  `QLAD_ASSERT_NEXT(a_last_wraps, clk_i, rst_ni, accept && last, dim_idx_q == '0,
                    "dimension counter did not wrap after last item")

endmodule

@@ hdl/qlad_back.sv @@
// Back part: squarer stage, saturating accumulator and result register.
`include "assert_macros.svh"

module qlad_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            work_valid_i,
  output logic            work_ready_o,
  input  qlad_pkg::work_t work_i,
  qlad_stream_if.source   out_o
);

  logic                        sq_vld_q;
  logic [qlad_pkg::SqW-1:0]    sq_q;
  logic                        sq_last_q;
  logic [qlad_pkg::SumW-1:0]   acc_q, acc_d;
  logic                        out_vld_q, out_vld_d;
  logic [qlad_pkg::SumW-1:0]   out_dist_q;
  logic [qlad_pkg::SumW:0]     sum_w;
  logic [qlad_pkg::SumW-1:0]   sum_sat;
  logic                        acc_fire, sq_load;

  // Accumulate held squares; a last one only when the result slot can take a finished distance
  assign acc_fire     = sq_vld_q && (!sq_last_q || !out_vld_q || out_o.ready);
  assign work_ready_o = !sq_vld_q || acc_fire;
  assign sq_load      = work_valid_i && work_ready_o;

  assign sum_w   = {1'b0, acc_q} + (qlad_pkg::SumW + 1)'(sq_q);
  assign sum_sat = sum_w[qlad_pkg::SumW] ? '1 : sum_w[qlad_pkg::SumW-1:0];

  always_comb begin
    acc_d     = acc_q;
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (acc_fire) begin
      acc_d = sq_last_q ? '0 : sum_sat;
      if (sq_last_q) begin
        out_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      sq_vld_q  <= sq_load || (sq_vld_q && !acc_fire);
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Squarer and result payload
  always_ff @(posedge clk_i) begin
    if (sq_load) begin
      sq_q      <= work_i.mag * work_i.mag;
      sq_last_q <= work_i.last;
    end
    if (acc_fire && sq_last_q) begin
      out_dist_q <= sum_sat;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.data.distance = out_dist_q;

  `QLAD_ASSERT_NEXT(a_acc_clear, clk_i, rst_ni, acc_fire && sq_last_q, acc_q == '0,
                    "accumulator not cleared after a result")

endmodule

@@ hdl/quantized_l2_asymmetric_distance_core.sv @@
// Squared L2 distance core: takes one vector dimension per request, one request per clock
// sustained while the output is not stalled, in exact mode (query minus peer) or codebook
// mode (query minus a centroid picked by a 1 to 4 bit packed index at the core's own
// dimension position). After the configured number of dimensions the 48-bit saturated sum is
// offered on the output and the accumulator clears. A last request passes the combinational
// front into the two-entry work queue at its accepting edge, then the 16x16 squarer, then the
// 48-bit saturating adder into the result register. The squarer and adder each take one
// request a clock, which sets the rate, unless a finished distance waits on a stalled output;
// the queue lets that output hold the back while the front accepts until the queue fills.
// Configuration writes are taken every cycle and are meant for idle.
module quantized_l2_asymmetric_distance_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  qlad_stream_if.sink   in_i,
  qlad_stream_if.sink   cfg_i,
  qlad_stream_if.source out_o
);

  logic            fr_valid, fr_ready;
  qlad_pkg::work_t fr_work;
  logic            bk_valid, bk_ready;
  qlad_pkg::work_t bk_work;

  qlad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .work_valid_o (fr_valid),
    .work_ready_i (fr_ready),
    .work_o       (fr_work)
  );

  qlad_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_work),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_work)
  );

  qlad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (bk_valid),
    .work_ready_o (bk_ready),
    .work_i       (bk_work),
    .out_o        (out_o)
  );

endmodule
